/* sv/sfd_pkg.sv */
`timescale 1ns / 1ps
// sfd_pkg: widths, control word layout, microcode table and saturation helpers
// for the stereo filter and delay chain; depends on nothing else

package sfd_pkg;

  // sample and fixed-point widths
  localparam int SAMPLE_W    = 24;
  localparam int FRAC_W      = 16;
  localparam int STATE_W     = SAMPLE_W + FRAC_W;
  localparam int COEF_W      = 17;
  localparam int HPC_W       = 16;
  localparam int LEN_W       = 15;
  localparam int CFG_W       = 17;
  localparam int REG_IDX_W   = 2;
  localparam int DELAY_DEPTH = 16384;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);

  // datapath widths: difference split into a high and a low part for the multiplier
  localparam int DIFF_W  = STATE_W + 1;
  localparam int LO_W    = SAMPLE_W;
  localparam int HI_W    = DIFF_W - LO_W;
  localparam int MA_W    = COEF_W + 1;
  localparam int MB_W    = SAMPLE_W + 1;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = COEF_W + DIFF_W + 1;
  localparam int UPD_W   = ACC_W - FRAC_W + 1;
  localparam int SAT_W   = PROD_W - FRAC_W;

  // register reset values
  localparam logic [COEF_W-1:0] LP_COEFF_RESET = COEF_W'(65536);
  localparam logic [HPC_W-1:0]  HP_COEFF_RESET = '0;
  localparam logic [COEF_W-1:0] GAIN_RESET     = COEF_W'(32768);
  localparam logic [LEN_W-1:0]  LENGTH_RESET   = LEN_W'(12000);

  // microcode sequencing
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_LOOP = '0;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LOWPASS  = 2'd0,
    REG_HIGHPASS = 2'd1,
    REG_FEEDBACK = 2'd2,
    REG_LENGTH   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_LP1 = 2'd0,
    ST_LP2 = 2'd1,
    ST_HP1 = 2'd2,
    ST_HP2 = 2'd3
  } st_sel_t;

  typedef enum logic [1:0] {
    TGT_X   = 2'd0,
    TGT_LP1 = 2'd1,
    TGT_LPY = 2'd2,
    TGT_HP1 = 2'd3
  } tgt_sel_t;

  typedef enum logic {
    COEF_LP = 1'b0,
    COEF_HP = 1'b1
  } coef_sel_t;

  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_HI   = 2'd1,
    MUL_LO   = 2'd2,
    MUL_GAIN = 2'd3
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NONE = 2'd0,
    JMP_CH0  = 2'd1,
    JMP_DONE = 2'd2
  } jmp_t;

  typedef struct packed {
    st_sel_t             st_sel;
    tgt_sel_t            tgt_sel;
    coef_sel_t           coef_sel;
    logic                diff_en;
    mul_sel_t            mul_sel;
    acc_op_t             acc_op;
    logic                st_we;
    logic                hpo_en;
    logic                dsum_en;
    logic                out_en;
    logic                dwr_en;
    jmp_t                jmp;
    logic [STEP_W-1:0]   target;
  } ctrl_word_t;

  typedef struct packed {
    ctrl_word_t          ctrl;
    logic [STEP_W-1:0]   step;
    logic                ch;
    logic                fin;
  } seq_out_t;

  typedef struct packed {
    logic                accept;
    logic                clr_we;
    logic [ADDR_W-1:0]   clr_addr;
  } dp_ctl_t;

  typedef struct packed {
    logic [COEF_W-1:0]   lp_coeff;
    logic [HPC_W-1:0]    hp_coeff;
    logic [COEF_W-1:0]   gain;
    logic [LEN_W-1:0]    length;
  } cfg_t;

  localparam ctrl_word_t CW_NOP = '{
    st_sel: ST_LP1, tgt_sel: TGT_X, coef_sel: COEF_LP, diff_en: 1'b0,
    mul_sel: MUL_NONE, acc_op: ACC_HOLD, st_we: 1'b0, hpo_en: 1'b0,
    dsum_en: 1'b0, out_en: 1'b0, dwr_en: 1'b0, jmp: JMP_NONE, target: '0
  };

  // microprogram for one channel, run once per channel
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = CW_NOP;
    case (step)
      // first low-pass section
      5'd0:  begin w.diff_en = 1'b1; w.st_sel = ST_LP1; w.tgt_sel = TGT_X; end
      5'd1:  begin w.mul_sel = MUL_HI; w.coef_sel = COEF_LP; end
      5'd2:  begin w.mul_sel = MUL_LO; w.coef_sel = COEF_LP; w.acc_op = ACC_LOAD; end
      5'd4:  begin w.st_we = 1'b1; w.st_sel = ST_LP1; end
      // second low-pass section
      5'd5:  begin w.diff_en = 1'b1; w.st_sel = ST_LP2; w.tgt_sel = TGT_LP1; end
      5'd6:  begin w.mul_sel = MUL_HI; w.coef_sel = COEF_LP; end
      5'd7:  begin w.mul_sel = MUL_LO; w.coef_sel = COEF_LP; w.acc_op = ACC_LOAD; end
      5'd9:  begin w.st_we = 1'b1; w.st_sel = ST_LP2; end
      // first high-pass smoothing section
      5'd10: begin w.diff_en = 1'b1; w.st_sel = ST_HP1; w.tgt_sel = TGT_LPY; end
      5'd11: begin w.mul_sel = MUL_HI; w.coef_sel = COEF_HP; end
      5'd12: begin w.mul_sel = MUL_LO; w.coef_sel = COEF_HP; w.acc_op = ACC_LOAD; end
      5'd14: begin w.st_we = 1'b1; w.st_sel = ST_HP1; end
      // second high-pass smoothing section
      5'd15: begin w.diff_en = 1'b1; w.st_sel = ST_HP2; w.tgt_sel = TGT_HP1; end
      5'd16: begin w.mul_sel = MUL_HI; w.coef_sel = COEF_HP; end
      5'd17: begin w.mul_sel = MUL_LO; w.coef_sel = COEF_HP; w.acc_op = ACC_LOAD; end
      5'd19: begin w.st_we = 1'b1; w.st_sel = ST_HP2; end
      // partial products summed
      5'd3, 5'd8, 5'd13, 5'd18: w.acc_op = ACC_ADD;
      // high-pass output, then delay tap
      5'd20: begin w.diff_en = 1'b1; w.st_sel = ST_HP2; w.tgt_sel = TGT_LPY; end
      5'd21: w.hpo_en = 1'b1;
      5'd22: w.dsum_en = 1'b1;
      5'd23: begin w.mul_sel = MUL_GAIN; w.out_en = 1'b1; end
      5'd24: begin w.dwr_en = 1'b1; w.jmp = JMP_CH0; w.target = STEP_LOOP; end
      5'd25: w.jmp = JMP_DONE;
      default: w.jmp = JMP_DONE;
    endcase
    return w;
  endfunction

  // clamp to the filter state width
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [UPD_W-1:0] v);
    logic [UPD_W-STATE_W:0] hi;
    hi = v[UPD_W-1:STATE_W-1];
    if (&hi || ~|hi) begin
      return v[STATE_W-1:0];
    end else if (v[UPD_W-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end
    return {1'b0, {(STATE_W-1){1'b1}}};
  endfunction

  // clamp to the sample width
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-SAMPLE_W:0] hi;
    hi = v[SAT_W-1:SAMPLE_W-1];
    if (&hi || ~|hi) begin
      return v[SAMPLE_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end
    return {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

endpackage

/* sv/sfd_in_if.sv */
`timescale 1ns / 1ps
// sfd_in_if: request channel carrying one stereo input frame
// depends on sfd_pkg for the sample width

interface sfd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sfd_pkg::SAMPLE_W-1:0]  left_in;
  logic signed [sfd_pkg::SAMPLE_W-1:0]  right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

/* sv/sfd_out_if.sv */
`timescale 1ns / 1ps
// sfd_out_if: request channel carrying one processed stereo frame
// depends on sfd_pkg for the sample width

interface sfd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sfd_pkg::SAMPLE_W-1:0]  left_out;
  logic signed [sfd_pkg::SAMPLE_W-1:0]  right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

/* sv/sfd_ram.sv */
`timescale 1ns / 1ps
// sfd_ram: generic single-write, single-read RAM with registered read data
// stands alone, no package needed

module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/sfd_sequencer.sv */
`timescale 1ns / 1ps
// sfd_sequencer: step counter, channel bit and microcode lookup with jumps
// depends on sfd_pkg for the control word and the program table

module sfd_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              run,
  input  logic              out_free,
  output sfd_pkg::seq_out_t seq
);

  logic [sfd_pkg::STEP_W-1:0] step;
  logic                       ch;
  sfd_pkg::ctrl_word_t        cw;
  logic                       fin;

  // control word for the current step
  assign cw  = sfd_pkg::ucode(step);
  assign fin = run && (cw.jmp == sfd_pkg::JMP_DONE) && out_free;

  assign seq.ctrl = cw;
  assign seq.step = step;
  assign seq.ch   = ch;
  assign seq.fin  = fin;

  // step counter; the last step holds while the output register is full and not being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      ch   <= 1'b0;
    end else if (start) begin
      step <= '0;
      ch   <= 1'b0;
    end else if (run) begin
      case (cw.jmp)
        sfd_pkg::JMP_NONE: begin
          step <= step + sfd_pkg::STEP_W'(1);
        end
        sfd_pkg::JMP_CH0: begin
          if (!ch) begin
            ch   <= 1'b1;
            step <= cw.target;
          end else begin
            step <= step + sfd_pkg::STEP_W'(1);
          end
        end
        sfd_pkg::JMP_DONE: begin
          if (out_free) begin
            step <= '0;
          end
        end
        default: begin
          step <= '0;
        end
      endcase
    end
  end

endmodule

/* sv/sfd_datapath.sv */
`timescale 1ns / 1ps
// sfd_datapath: filter states, shared multiplier, accumulator, delay store
// depends on sfd_pkg and sfd_ram

module sfd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  sfd_pkg::cfg_t                       cfg,
  input  sfd_pkg::seq_out_t                   seq,
  input  sfd_pkg::dp_ctl_t                    ctl,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] right_in,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] right_out
);

  localparam int SW = sfd_pkg::SAMPLE_W;
  localparam int TW = sfd_pkg::STATE_W;
  localparam int FW = sfd_pkg::FRAC_W;
  localparam int DW = sfd_pkg::DIFF_W;
  localparam int LW = sfd_pkg::LO_W;
  localparam int HW = sfd_pkg::HI_W;
  localparam int AW = sfd_pkg::ACC_W;
  localparam int PW = sfd_pkg::PROD_W;
  localparam int BW = sfd_pkg::MB_W;
  localparam int UW = sfd_pkg::UPD_W;
  localparam int QW = sfd_pkg::SAT_W;
  localparam int RW = sfd_pkg::ADDR_W;
  localparam int NW = sfd_pkg::LEN_W;

  sfd_pkg::ctrl_word_t cw;
  logic                ch;

  logic signed [SW-1:0] x      [2];
  logic signed [TW-1:0] lp1    [2];
  logic signed [TW-1:0] lp2    [2];
  logic signed [TW-1:0] hp1    [2];
  logic signed [TW-1:0] hp2    [2];
  logic signed [SW-1:0] res    [2];
  logic signed [SW-1:0] dnew   [2];

  logic signed [TW-1:0]             s_cur;
  logic signed [TW-1:0]             t_cur;
  logic signed [DW-1:0]             diff;
  logic signed [sfd_pkg::MA_W-1:0]  mul_a;
  logic signed [BW-1:0]             mul_b;
  logic signed [PW-1:0]             prod;
  logic signed [AW-1:0]             acc;
  logic signed [UW-1:0]             upd_sum;
  logic signed [TW-1:0]             st_new;
  logic signed [SW-1:0]             z;
  logic signed [BW-1:0]             sum;
  logic signed [SW-1:0]             d_ch;

  logic [RW-1:0]   pos;
  logic [NW-1:0]   len_eff;
  logic [NW-1:0]   pos_inc;
  logic [2*SW-1:0] ram_rdata;
  logic            ram_we;
  logic [RW-1:0]   ram_waddr;
  logic [2*SW-1:0] ram_wdata;

  assign cw = seq.ctrl;
  assign ch = seq.ch;

  // state operand of the current one-pole step
  always_comb begin
    case (cw.st_sel)
      sfd_pkg::ST_LP1: s_cur = lp1[ch];
      sfd_pkg::ST_LP2: s_cur = lp2[ch];
      sfd_pkg::ST_HP1: s_cur = hp1[ch];
      default:         s_cur = hp2[ch];
    endcase
  end

  // target operand, in the same q.16 format
  always_comb begin
    case (cw.tgt_sel)
      sfd_pkg::TGT_X:   t_cur = {x[ch], {FW{1'b0}}};
      sfd_pkg::TGT_LP1: t_cur = lp1[ch];
      sfd_pkg::TGT_LPY: t_cur = {lp2[ch][TW-1:FW], {FW{1'b0}}};
      default:          t_cur = hp1[ch];
    endcase
  end

  // multiplier operands: coefficient times one half of the difference, or gain
  always_comb begin
    if (cw.mul_sel == sfd_pkg::MUL_GAIN) begin
      mul_a = {1'b0, cfg.gain};
    end else if (cw.coef_sel == sfd_pkg::COEF_HP) begin
      mul_a = {2'b00, cfg.hp_coeff};
    end else begin
      mul_a = {1'b0, cfg.lp_coeff};
    end
    case (cw.mul_sel)
      sfd_pkg::MUL_HI: mul_b = {{(BW-HW){diff[DW-1]}}, diff[DW-1:LW]};
      sfd_pkg::MUL_LO: mul_b = {1'b0, diff[LW-1:0]};
      default:         mul_b = sum;
    endcase
  end

  // state update: s + floor(acc / 65536), clamped
  assign upd_sum = {{(UW-TW){s_cur[TW-1]}}, s_cur}
                 + {{(UW-(AW-FW)){acc[AW-1]}}, acc[AW-1:FW]};
  assign st_new  = sfd_pkg::sat_state(upd_sum);

  assign d_ch = ch ? ram_rdata[2*SW-1:SW] : ram_rdata[SW-1:0];

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      x[0] <= left_in;
      x[1] <= right_in;
    end
    if (cw.diff_en) begin
      diff <= {t_cur[TW-1], t_cur} - {s_cur[TW-1], s_cur};
    end
    if (cw.mul_sel != sfd_pkg::MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    case (cw.acc_op)
      sfd_pkg::ACC_LOAD: acc <= {prod[AW-LW-1:0], {LW{1'b0}}};
      sfd_pkg::ACC_ADD:  acc <= acc + {{(AW-PW){prod[PW-1]}}, prod};
      default:           acc <= acc;
    endcase
    if (cw.hpo_en) begin
      z <= sfd_pkg::sat_sample({{(QW-(DW-FW)){diff[DW-1]}}, diff[DW-1:FW]});
    end
    if (cw.dsum_en) begin
      sum <= {z[SW-1], z} + {d_ch[SW-1], d_ch};
    end
    if (cw.out_en) begin
      res[ch] <= sfd_pkg::sat_sample({{(QW-BW){sum[BW-1]}}, sum});
    end
    if (cw.dwr_en) begin
      dnew[ch] <= sfd_pkg::sat_sample(prod[PW-1:FW]);
    end
    if (seq.fin) begin
      left_out  <= res[0];
      right_out <= res[1];
    end
  end

  // filter states, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      lp1 <= '{default: '0};
      lp2 <= '{default: '0};
      hp1 <= '{default: '0};
      hp2 <= '{default: '0};
    end else if (cw.st_we) begin
      case (cw.st_sel)
        sfd_pkg::ST_LP1: lp1[ch] <= st_new;
        sfd_pkg::ST_LP2: lp2[ch] <= st_new;
        sfd_pkg::ST_HP1: hp1[ch] <= st_new;
        default:         hp2[ch] <= st_new;
      endcase
    end
  end

  // delay position, wrapping at the clamped length
  always_comb begin
    if (cfg.length == '0) begin
      len_eff = NW'(1);
    end else if (cfg.length > NW'(sfd_pkg::DELAY_DEPTH)) begin
      len_eff = NW'(sfd_pkg::DELAY_DEPTH);
    end else begin
      len_eff = cfg.length;
    end
  end

  assign pos_inc = NW'(pos) + NW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (seq.fin) begin
      pos <= (pos_inc >= len_eff) ? '0 : pos_inc[RW-1:0];
    end
  end

  // delay store: both channels share one row, cleared after reset
  assign ram_we    = ctl.clr_we || seq.fin;
  assign ram_waddr = ctl.clr_we ? ctl.clr_addr : pos;
  assign ram_wdata = ctl.clr_we ? '0 : {dnew[1], dnew[0]};

  sfd_ram #(
    .WIDTH (2 * sfd_pkg::SAMPLE_W),
    .DEPTH (sfd_pkg::DELAY_DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.accept),
    .raddr (pos),
    .rdata (ram_rdata)
  );

endmodule

/* sv/stereo_filter_delay_chain.sv */
`timescale 1ns / 1ps
// stereo_filter_delay_chain: top level with control fsm, registers and output stage
// depends on sfd_pkg, sfd_in_if, sfd_out_if, sfd_sequencer and sfd_datapath
//
//   channel   dir   handshake        payload
//   frame     in    valid / ready    left_in, right_in (signed 24 bit)
//   result    out   valid / ready    left_out, right_out (signed 24 bit)
//   wr_*      in    wr_en            wr_index (2 bit), wr_data (17 bit)
//
// a frame is accepted from idle and then runs 51 microcode steps, 25 per channel
// and one final step; the single shared 18 x 25 multiplier sets that step count.
// after reset a clearing pass writes the 16384-row delay store, one row a cycle,
// and frames are refused until it ends; register writes still land.
// a result waits in the output register; the next frame may be accepted meanwhile,
// and its final step holds only if the previous result is still not taken.

module stereo_filter_delay_chain (
  input  logic                              clk,
  input  logic                              rst,
  sfd_in_if.sink                            frame,
  sfd_out_if.source                         result,
  input  logic                              wr_en,
  input  logic [sfd_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [sfd_pkg::CFG_W-1:0]         wr_data
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_RUN   = 3'b100
  } fsm_t;

  fsm_t                        state;
  logic [sfd_pkg::ADDR_W-1:0]  clr_addr;
  logic                        out_valid;
  logic                        accept;
  logic                        out_free;
  sfd_pkg::cfg_t               cfg;
  sfd_pkg::seq_out_t           seq;
  sfd_pkg::dp_ctl_t            ctl;

  assign frame.ready  = (state == S_IDLE);
  assign accept       = frame.valid && frame.ready;
  assign out_free     = !out_valid || result.ready;
  assign result.valid = out_valid;

  assign ctl.accept   = accept;
  assign ctl.clr_we   = (state == S_CLEAR);
  assign ctl.clr_addr = clr_addr;

  // control fsm and clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + sfd_pkg::ADDR_W'(1);
          if (clr_addr == sfd_pkg::ADDR_W'(sfd_pkg::DELAY_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (seq.fin) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq.fin) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lp_coeff <= sfd_pkg::LP_COEFF_RESET;
      cfg.hp_coeff <= sfd_pkg::HP_COEFF_RESET;
      cfg.gain     <= sfd_pkg::GAIN_RESET;
      cfg.length   <= sfd_pkg::LENGTH_RESET;
    end else if (wr_en) begin
      case (wr_index)
        sfd_pkg::REG_LOWPASS:  cfg.lp_coeff <= wr_data[sfd_pkg::COEF_W-1:0];
        sfd_pkg::REG_HIGHPASS: cfg.hp_coeff <= wr_data[sfd_pkg::HPC_W-1:0];
        sfd_pkg::REG_FEEDBACK: cfg.gain     <= wr_data[sfd_pkg::COEF_W-1:0];
        sfd_pkg::REG_LENGTH:   cfg.length   <= wr_data[sfd_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sfd_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .run      (state == S_RUN),
    .out_free (out_free),
    .seq      (seq)
  );

  sfd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .seq       (seq),
    .ctl       (ctl),
    .left_in   (frame.left_in),
    .right_in  (frame.right_in),
    .left_out  (result.left_out),
    .right_out (result.right_out)
  );

  // a new frame starts the program at its first step on the left channel
  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_RUN && seq.step == '0 && !seq.ch))
    else $error("frame accepted but program did not start");

  // the program finishes only from the run state after the right channel
  a_fin: assert property (@(posedge clk) disable iff (rst)
    seq.fin |-> (state == S_RUN && seq.ch))
    else $error("program finished outside the right channel pass");

  // a result appears only after the final step fires
  a_load: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(seq.fin))
    else $error("result raised without a finished frame");

  // nothing is produced during the clearing pass
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!result.valid && !seq.fin))
    else $error("activity during delay store clearing");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for stereo_filter_delay_chain, with a cycle-accurate-free predictor
// of the filter cascade and feedback delay; depends on sfd_pkg, sfd_in_if, sfd_out_if and the rtl

module tb;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 133;
  localparam int TAIL_CYCLES     = 60;
  localparam int PLAN_LEN        = 24;

  typedef enum logic [1:0] {
    ROW_FIXED = 2'd0,
    ROW_FRAME = 2'd1,
    ROW_WRITE = 2'd2
  } row_kind_t;

  typedef struct packed {
    row_kind_t                            kind;
    sfd_pkg::reg_idx_t                    idx;
    logic [sfd_pkg::CFG_W-1:0]            value;
    logic signed [sfd_pkg::SAMPLE_W-1:0]  left;
    logic signed [sfd_pkg::SAMPLE_W-1:0]  right;
    logic signed [sfd_pkg::SAMPLE_W-1:0]  want_left;
    logic signed [sfd_pkg::SAMPLE_W-1:0]  want_right;
  } plan_row_t;

  typedef struct packed {
    logic signed [sfd_pkg::SAMPLE_W-1:0]  left;
    logic signed [sfd_pkg::SAMPLE_W-1:0]  right;
  } stereo_t;

  // directed rows: reset settings pass samples straight through, then the corner settings
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{ROW_FIXED, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh000000, 24'sh000000, 24'sh000000, 24'sh000000},
    '{ROW_FIXED, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000},
    '{ROW_FIXED, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF},
    '{ROW_FIXED, sfd_pkg::REG_LOWPASS, 17'd0, 24'shFFFFFF, 24'sh000001, 24'shFFFFFF, 24'sh000001},
    '{ROW_FIXED, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA},
    '{ROW_FIXED, sfd_pkg::REG_LOWPASS, 17'd0, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 24'sh555555},
    '{ROW_FIXED, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF},
    '{ROW_FIXED, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000},
    // length cut below the current position
    '{ROW_WRITE, sfd_pkg::REG_LENGTH, 17'd4, 24'sh0, 24'sh0, 24'sh0, 24'sh0},
    '{ROW_FRAME, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh123456, 24'shEDCBA9, 24'sh0, 24'sh0},
    '{ROW_FRAME, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh7FFFFF, 24'sh800000, 24'sh0, 24'sh0},
    // zero length behaves as one
    '{ROW_WRITE, sfd_pkg::REG_LENGTH, 17'd0, 24'sh0, 24'sh0, 24'sh0, 24'sh0},
    '{ROW_FRAME, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh400000, 24'shC00000, 24'sh0, 24'sh0},
    '{ROW_FRAME, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh0, 24'sh0},
    '{ROW_FRAME, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh800000, 24'sh000000, 24'sh0, 24'sh0},
    // low-pass coefficient and gain above unity, high-pass coefficient at its maximum, oversized length
    '{ROW_WRITE, sfd_pkg::REG_LOWPASS, 17'h1FFFF, 24'sh0, 24'sh0, 24'sh0, 24'sh0},
    '{ROW_WRITE, sfd_pkg::REG_HIGHPASS, 17'h0FFFF, 24'sh0, 24'sh0, 24'sh0, 24'sh0},
    '{ROW_WRITE, sfd_pkg::REG_FEEDBACK, 17'h1FFFF, 24'sh0, 24'sh0, 24'sh0, 24'sh0},
    '{ROW_WRITE, sfd_pkg::REG_LENGTH, 17'h07FFF, 24'sh0, 24'sh0, 24'sh0, 24'sh0},
    '{ROW_FRAME, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh7FFFFF, 24'sh800000, 24'sh0, 24'sh0},
    '{ROW_FRAME, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh7FFFFF, 24'sh800000, 24'sh0, 24'sh0},
    '{ROW_FRAME, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh800000, 24'sh7FFFFF, 24'sh0, 24'sh0},
    '{ROW_FRAME, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh000000, 24'sh000000, 24'sh0, 24'sh0},
    '{ROW_FRAME, sfd_pkg::REG_LOWPASS, 17'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh0, 24'sh0}
  };

  logic                          clk;
  logic                          rst;
  logic                          wr_en;
  logic [sfd_pkg::REG_IDX_W-1:0] wr_index;
  logic [sfd_pkg::CFG_W-1:0]     wr_data;

  sfd_in_if  frame_bus ();
  sfd_out_if result_bus ();

  stereo_filter_delay_chain dut (
    .clk      (clk),
    .rst      (rst),
    .frame    (frame_bus),
    .result   (result_bus),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // predictor state, per channel filters and the shared delay store
  longint                              lp_a [2];
  longint                              lp_b [2];
  longint                              hp_a [2];
  longint                              hp_b [2];
  logic signed [sfd_pkg::SAMPLE_W-1:0] echo_store [2*sfd_pkg::DELAY_DEPTH];
  int unsigned                         tap_pos;
  logic [sfd_pkg::COEF_W-1:0]          lp_c;
  logic [sfd_pkg::HPC_W-1:0]           hp_c;
  logic [sfd_pkg::COEF_W-1:0]          fb_gain;
  logic [sfd_pkg::LEN_W-1:0]           echo_len;

  stereo_t due_outputs [$];
  int      mismatches = 0;
  int      cycle_count = 0;
  bit      steady;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clamp_bits(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // one-pole section: s + floor(c * (t - s) / 2^16), clamped to the state width
  function automatic longint smooth(input longint s, input longint t, input longint c);
    return clamp_bits(s + ((c * (t - s)) >>> sfd_pkg::FRAC_W), sfd_pkg::STATE_W);
  endfunction

  // low-pass, high-pass and delay tap for both channels of one frame
  function automatic stereo_t filter_delay_step(
      input logic signed [sfd_pkg::SAMPLE_W-1:0] left,
      input logic signed [sfd_pkg::SAMPLE_W-1:0] right);
    stereo_t     res;
    int unsigned span;
    int unsigned pos;
    int unsigned slot;
    longint      x;
    longint      y;
    longint      z;
    longint      d;
    longint      o;
    span = echo_len;
    if (span == 0) span = 1;
    if (span > sfd_pkg::DELAY_DEPTH) span = sfd_pkg::DELAY_DEPTH;
    pos = tap_pos % sfd_pkg::DELAY_DEPTH;
    for (int ch = 0; ch < 2; ch++) begin
      x = (ch == 0) ? left : right;
      slot = ch * sfd_pkg::DELAY_DEPTH + pos;
      lp_a[ch] = smooth(lp_a[ch], x * 65536, longint'(lp_c));
      lp_b[ch] = smooth(lp_b[ch], lp_a[ch], longint'(lp_c));
      y = clamp_bits(lp_b[ch] >>> sfd_pkg::FRAC_W, sfd_pkg::SAMPLE_W);
      hp_a[ch] = smooth(hp_a[ch], y * 65536, longint'(hp_c));
      hp_b[ch] = smooth(hp_b[ch], hp_a[ch], longint'(hp_c));
      z = clamp_bits((y * 65536 - hp_b[ch]) >>> sfd_pkg::FRAC_W, sfd_pkg::SAMPLE_W);
      d = echo_store[slot];
      o = clamp_bits(z + d, sfd_pkg::SAMPLE_W);
      echo_store[slot] = sfd_pkg::SAMPLE_W'(
          clamp_bits(((d + z) * longint'(fb_gain)) >>> sfd_pkg::FRAC_W, sfd_pkg::SAMPLE_W));
      if (ch == 0) res.left = sfd_pkg::SAMPLE_W'(o);
      else res.right = sfd_pkg::SAMPLE_W'(o);
    end
    pos++;
    if (pos >= span) pos = 0;
    tap_pos = pos;
    return res;
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(4, 1);
    return $urandom_range(80, 20);
  endfunction

  function automatic logic signed [sfd_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return {1'b0, {(sfd_pkg::SAMPLE_W-1){1'b1}}};
      1: return {1'b1, {(sfd_pkg::SAMPLE_W-1){1'b0}}};
      2: return sfd_pkg::SAMPLE_W'($urandom_range(2000) - 1000);
      default: return sfd_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  // one register write; wr_en drops only after the last of a burst
  task automatic cfg_write(input sfd_pkg::reg_idx_t idx,
                           input logic [sfd_pkg::CFG_W-1:0] value, input bit last);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    case (idx)
      sfd_pkg::REG_LOWPASS:  lp_c     = value[sfd_pkg::COEF_W-1:0];
      sfd_pkg::REG_HIGHPASS: hp_c     = value[sfd_pkg::HPC_W-1:0];
      sfd_pkg::REG_FEEDBACK: fb_gain  = value[sfd_pkg::COEF_W-1:0];
      sfd_pkg::REG_LENGTH:   echo_len = value[sfd_pkg::LEN_W-1:0];
      default: begin
      end
    endcase
    @(posedge clk);
    if (last) wr_en <= 1'b0;
  endtask

  // offer one frame request, record its expected output once taken, then maybe pause
  task automatic push_frame(input logic signed [sfd_pkg::SAMPLE_W-1:0] left,
                            input logic signed [sfd_pkg::SAMPLE_W-1:0] right,
                            input bit fixed,
                            input logic signed [sfd_pkg::SAMPLE_W-1:0] want_left,
                            input logic signed [sfd_pkg::SAMPLE_W-1:0] want_right);
    stereo_t predicted;
    int      gap;
    frame_bus.valid    <= 1'b1;
    frame_bus.left_in  <= left;
    frame_bus.right_in <= right;
    do @(posedge clk); while (!frame_bus.ready);
    predicted = filter_delay_step(left, right);
    if (fixed) due_outputs.push_back(stereo_t'{left: want_left, right: want_right});
    else due_outputs.push_back(predicted);
    gap = idle_len();
    if (gap > 0) begin
      frame_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off requests until every expected output has been taken
  task automatic settle();
    frame_bus.valid <= 1'b0;
    do @(posedge clk); while (due_outputs.size() != 0);
  endtask

  // result side: random back-pressure and field checks
  initial begin
    int      hold;
    stereo_t want;
    hold = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_bus.valid && result_bus.ready) begin
        if (due_outputs.size() == 0) begin
          mismatches++;
          $error("unexpected result: left_out %0d right_out %0d",
                 result_bus.left_out, result_bus.right_out);
        end else begin
          want = due_outputs.pop_front();
          if (result_bus.left_out !== want.left) begin
            mismatches++;
            $error("left_out: expected %0d, got %0d", want.left, result_bus.left_out);
          end
          if (result_bus.right_out !== want.right) begin
            mismatches++;
            $error("right_out: expected %0d, got %0d", want.right, result_bus.right_out);
          end
        end
      end
      if (hold > 0) hold--;
      else hold = idle_len();
      result_bus.ready <= (hold == 0);
    end
  end

  // run limit, allowing for the store clearing pass after reset
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_count, due_outputs.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [sfd_pkg::CFG_W-1:0] lp_v;
    logic [sfd_pkg::CFG_W-1:0] hp_v;
    logic [sfd_pkg::CFG_W-1:0] gain_v;
    logic [sfd_pkg::CFG_W-1:0] len_v;
    steady              = 1'b0;
    rst                <= 1'b1;
    wr_en              <= 1'b0;
    wr_index           <= '0;
    wr_data            <= '0;
    frame_bus.valid    <= 1'b0;
    frame_bus.left_in  <= '0;
    frame_bus.right_in <= '0;

    // predictor reset
    for (int ch = 0; ch < 2; ch++) begin
      lp_a[ch] = 0;
      lp_b[ch] = 0;
      hp_a[ch] = 0;
      hp_b[ch] = 0;
    end
    foreach (echo_store[k]) echo_store[k] = '0;
    tap_pos  = 0;
    lp_c     = sfd_pkg::LP_COEFF_RESET;
    hp_c     = sfd_pkg::HP_COEFF_RESET;
    fb_gain  = sfd_pkg::GAIN_RESET;
    echo_len = sfd_pkg::LENGTH_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].kind == ROW_WRITE) begin
        if (i == 0 || PLAN[i-1].kind != ROW_WRITE) settle();
        cfg_write(PLAN[i].idx, PLAN[i].value,
                  i == PLAN_LEN - 1 || PLAN[i+1].kind != ROW_WRITE);
      end else begin
        push_frame(PLAN[i].left, PLAN[i].right, PLAN[i].kind == ROW_FIXED,
                   PLAN[i].want_left, PLAN[i].want_right);
      end
    end

    // random phases, each under its own settings
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      steady = (phase % 4 == 3);
      case (phase)
        0: begin
          lp_v = 17'd655; hp_v = 17'd0; gain_v = 17'd0; len_v = 17'd1;
        end
        1: begin
          lp_v = 17'd65536; hp_v = 17'd64881; gain_v = 17'd65536; len_v = 17'd16384;
        end
        default: begin
          case ($urandom_range(9))
            0: lp_v = 17'd655;
            1: lp_v = 17'd65536;
            2: lp_v = $urandom_range(131071);
            default: lp_v = $urandom_range(65536, 655);
          endcase
          case ($urandom_range(9))
            0: hp_v = 17'd0;
            1: hp_v = 17'd64881;
            2: hp_v = $urandom_range(65535);
            default: hp_v = $urandom_range(64881);
          endcase
          case ($urandom_range(9))
            0: gain_v = 17'd0;
            1: gain_v = 17'd65536;
            2: gain_v = $urandom_range(131071);
            default: gain_v = $urandom_range(65536);
          endcase
          case ($urandom_range(9))
            0: len_v = 17'd0;
            1: len_v = 17'd16384;
            2: len_v = $urandom_range(32767);
            3: len_v = 17'd12000;
            default: len_v = $urandom_range(48, 1);
          endcase
        end
      endcase
      cfg_write(sfd_pkg::REG_LOWPASS, lp_v, 1'b0);
      cfg_write(sfd_pkg::REG_HIGHPASS, hp_v, 1'b0);
      cfg_write(sfd_pkg::REG_FEEDBACK, gain_v, 1'b0);
      cfg_write(sfd_pkg::REG_LENGTH, len_v, 1'b1);
      for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
        // sender holds back mid-phase until the pipeline is empty
        if (phase % 2 == 0 && j == ITEMS_PER_PHASE / 2) settle();
        push_frame(pick_sample(), pick_sample(), 1'b0, '0, '0);
      end
    end

    settle();
    steady = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sfd_pkg.sv
sv/sfd_in_if.sv
sv/sfd_out_if.sv
sv/sfd_ram.sv
sv/sfd_sequencer.sv
sv/sfd_datapath.sv
sv/stereo_filter_delay_chain.sv
dv/tb.sv
